// File: design/seqno_replay_window_check_core_defines.svh
`ifndef SEQNO_REPLAY_WINDOW_CHECK_CORE_DEFINES_SVH
`define SEQNO_REPLAY_WINDOW_CHECK_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRWC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/srwc_pkg.sv
`timescale 1ns / 1ps

package srwc_pkg;

    localparam int SEQ_W            = 32;
    localparam int MAX_WINDOW_BYTES = 16;
    localparam int WB_W             = 5;
    localparam int FC_W             = 8;
    localparam int VERDICT_W        = 2;
    localparam int BIT_W            = 3;
    localparam int BYTE_W           = 8;

    localparam int IDX_W = (MAX_WINDOW_BYTES > 1) ? $clog2(MAX_WINDOW_BYTES) : 1;
    localparam int W_W   = $clog2(MAX_WINDOW_BYTES + 1);
    localparam int CNT_W = $clog2(MAX_WINDOW_BYTES * BYTE_W);

    // remainder unit: MOD_DIGIT dividend bits per cycle
    localparam int DIV_W     = SEQ_W - BIT_W;
    localparam int MOD_DIGIT = 4;
    localparam int MOD_STEPS = (DIV_W + MOD_DIGIT - 1) / MOD_DIGIT;
    localparam int DIV_PAD   = MOD_STEPS * MOD_DIGIT;
    localparam int STEP_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    localparam int IN_DATA_W  = ((SEQ_W + 7) / 8) * 8;
    localparam int OUT_BITS   = VERDICT_W + SEQ_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_LIMIT    = 1'b1;

    localparam logic [WB_W-1:0]  WB_RESET    = 5'd16;
    localparam logic [SEQ_W-1:0] LIMIT_RESET = 32'h4000_0000;
    localparam logic [FC_W-1:0]  FC_MAX      = 8'hFF;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_ACCEPT    = 2'd0,
        VERDICT_RESYNC    = 2'd1,
        VERDICT_DROP_FAR  = 2'd2,
        VERDICT_DROP_LATE = 2'd3
    } t_verdict;

    typedef enum logic [2:0] {
        ACT_BYPASS,
        ACT_ACCEPT,
        ACT_RESYNC,
        ACT_DROP_FAR,
        ACT_DROP_LATE
    } t_act;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic load_walk;
        logic walk_step;
        logic commit;
        t_act act;
    } t_dp_cmd;

    typedef struct packed {
        logic en;
        logic next;
        logic far;
        logic late;
        logic too_old;
        logic bit_set;
        logic fc_lt;
        logic walk_done;
        logic out_busy;
    } t_dp_sts;

endpackage

// File: design/srwc_dp.sv
`timescale 1ns / 1ps

module srwc_dp import srwc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [SEQ_W-1:0]      i_seq,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    logic [WB_W-1:0]    r_window_bytes;
    logic [SEQ_W-1:0]   r_seq_limit;
    logic [SEQ_W-1:0]   r_hs;
    logic [FC_W-1:0]    r_fc;
    logic [BYTE_W-1:0]  r_bitmap [MAX_WINDOW_BYTES];

    logic [SEQ_W-1:0]   r_seq;
    logic [DIV_PAD-1:0] r_div;
    logic [IDX_W-1:0]   r_rem;

    logic [SEQ_W-1:0]   r_end;
    logic [SEQ_W-1:0]   r_low;
    logic [SEQ_W-1:0]   r_lost;
    logic               r_next;
    logic               r_gt;

    logic [IDX_W-1:0]   r_widx;
    logic [BIT_W-1:0]   r_wbit;
    logic [CNT_W-1:0]   r_wcnt;

    logic               r_out_valid;
    t_verdict           r_out_verdict;
    logic [SEQ_W-1:0]   r_out_lost;
    logic               r_out_exp;

    logic [W_W-1:0]     w_eff;
    logic [SEQ_W-1:0]   span32;
    logic [IDX_W:0]     mod_t;
    logic [IDX_W-1:0]   n_rem;
    logic [IDX_W-1:0]   n_widx;
    logic [BIT_W-1:0]   n_wbit;
    logic [SEQ_W-1:0]   hs_new;
    logic               exp_new;

    // window clamped to the bitmap size
    assign w_eff  = (SEQ_W'(r_window_bytes) > SEQ_W'(MAX_WINDOW_BYTES))
                  ? W_W'(MAX_WINDOW_BYTES) : W_W'(r_window_bytes);
    assign span32 = SEQ_W'(w_eff) << BIT_W;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_bytes <= WB_RESET;
            r_seq_limit    <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW_BYTES: r_window_bytes <= i_cfg_data[WB_W-1:0];
                REG_SEQ_LIMIT:    r_seq_limit    <= i_cfg_data[SEQ_W-1:0];
                default:          r_seq_limit    <= r_seq_limit;
            endcase
        end
    end

    // restoring remainder, MOD_DIGIT bits per step
    always_comb begin
        n_rem = r_rem;
        mod_t = '0;
        for (int k = 0; k < MOD_DIGIT; k++) begin
            mod_t = {n_rem, r_div[DIV_PAD-1-k]};
            if (mod_t >= (IDX_W+1)'(w_eff)) begin
                mod_t = mod_t - (IDX_W+1)'(w_eff);
            end
            n_rem = mod_t[IDX_W-1:0];
        end
    end

    // walker moves one sequence number down, wrapping the byte index at w
    always_comb begin
        if (r_wbit == '0) begin
            n_wbit = BIT_W'(BYTE_W - 1);
            n_widx = (r_widx == '0) ? IDX_W'(w_eff - 1'b1) : r_widx - 1'b1;
        end else begin
            n_wbit = r_wbit - 1'b1;
            n_widx = r_widx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_seq <= i_seq;
            r_div <= DIV_PAD'(i_seq[SEQ_W-1:BIT_W]);
            r_rem <= '0;
        end else if (i_cmd.mod_step) begin
            r_div <= r_div << MOD_DIGIT;
            r_rem <= n_rem;
        end
    end

    // r_seq and r_hs hold still while an item is in work
    always_ff @(posedge i_clk) begin
        r_end  <= r_hs + span32;
        r_low  <= r_hs - span32;
        r_lost <= r_seq - r_hs - SEQ_W'(1);
        r_next <= (r_seq == r_hs + SEQ_W'(1));
        r_gt   <= (r_seq > r_hs);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_walk) begin
            r_widx <= r_rem;
            r_wbit <= r_seq[BIT_W-1:0];
            r_wcnt <= r_lost[CNT_W-1:0];
        end else if (i_cmd.walk_step) begin
            r_widx <= n_widx;
            r_wbit <= n_wbit;
            r_wcnt <= r_wcnt - 1'b1;
        end
    end

    // resync clears the whole window, which already covers the own bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WINDOW_BYTES; i++) begin
                r_bitmap[i] <= '0;
            end
        end else if (i_cmd.walk_step) begin
            r_bitmap[n_widx][n_wbit] <= 1'b1;
        end else if (i_cmd.commit) begin
            if (i_cmd.act == ACT_RESYNC) begin
                for (int i = 0; i < MAX_WINDOW_BYTES; i++) begin
                    if (SEQ_W'(i) < SEQ_W'(w_eff)) begin
                        r_bitmap[i] <= '0;
                    end
                end
            end else if (i_cmd.act == ACT_ACCEPT) begin
                r_bitmap[r_rem][r_seq[BIT_W-1:0]] <= 1'b0;
            end
        end
    end

    assign hs_new  = r_gt ? r_seq : r_hs;
    assign exp_new = (hs_new > r_seq_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs        <= '0;
            r_fc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                case (i_cmd.act)
                    ACT_BYPASS: r_hs <= hs_new;
                    ACT_ACCEPT,
                    ACT_RESYNC: begin
                        r_hs <= hs_new;
                        r_fc <= '0;
                    end
                    ACT_DROP_FAR: begin
                        if (r_fc != FC_MAX) begin
                            r_fc <= r_fc + 1'b1;
                        end
                    end
                    default: r_fc <= r_fc;
                endcase
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            case (i_cmd.act)
                ACT_BYPASS,
                ACT_ACCEPT: begin
                    r_out_verdict <= VERDICT_ACCEPT;
                    r_out_lost    <= '0;
                    r_out_exp     <= exp_new;
                end
                ACT_RESYNC: begin
                    r_out_verdict <= VERDICT_RESYNC;
                    r_out_lost    <= r_lost;
                    r_out_exp     <= exp_new;
                end
                ACT_DROP_FAR: begin
                    r_out_verdict <= VERDICT_DROP_FAR;
                    r_out_lost    <= r_lost;
                    r_out_exp     <= 1'b0;
                end
                default: begin
                    r_out_verdict <= VERDICT_DROP_LATE;
                    r_out_lost    <= '0;
                    r_out_exp     <= 1'b0;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = OUT_DATA_W'({r_out_exp, r_out_lost, r_out_verdict});

    always_comb begin
        o_sts.en        = (w_eff != '0);
        o_sts.next      = r_next;
        o_sts.far       = (r_seq >= r_end);
        o_sts.late      = (r_seq <= r_hs);
        o_sts.too_old   = (r_hs >= span32) && (r_seq <= r_low);
        o_sts.bit_set   = r_bitmap[r_rem][r_seq[BIT_W-1:0]];
        o_sts.fc_lt     = (r_fc < FC_W'(w_eff >> 2));
        o_sts.walk_done = (r_wcnt == '0);
        o_sts.out_busy  = r_out_valid && !i_out_ready;
    end

endmodule

// File: design/srwc_ctrl.sv
`timescale 1ns / 1ps
`include "seqno_replay_window_check_core_defines.svh"

module srwc_ctrl import srwc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_DECIDE,
        ST_FILL,
        ST_FINISH
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    t_act              r_act;

    t_act              n_act;
    logic              gap;

    // verdict path from the classified sequence number
    always_comb begin
        gap = 1'b0;
        if (!i_sts.en) begin
            n_act = ACT_BYPASS;
        end else if (i_sts.next) begin
            n_act = ACT_ACCEPT;
        end else if (i_sts.far) begin
            n_act = i_sts.fc_lt ? ACT_DROP_FAR : ACT_RESYNC;
        end else if (i_sts.late) begin
            n_act = (i_sts.too_old || !i_sts.bit_set) ? ACT_DROP_LATE : ACT_ACCEPT;
        end else begin
            n_act = ACT_ACCEPT;
            gap   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_act   <= ACT_BYPASS;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_step <= '0;
                    if (i_in_valid) begin
                        r_state <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(MOD_STEPS - 1)) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_act   <= n_act;
                    r_state <= gap ? ST_FILL : ST_FINISH;
                end
                ST_FILL: begin
                    if (i_sts.walk_done) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!i_sts.out_busy) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd.load      = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.mod_step  = (r_state == ST_MOD);
        o_cmd.load_walk = (r_state == ST_DECIDE);
        o_cmd.walk_step = (r_state == ST_FILL) && !i_sts.walk_done;
        o_cmd.commit    = (r_state == ST_FINISH) && !i_sts.out_busy;
        o_cmd.act       = r_act;
    end

    `SRWC_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "second transaction taken while one is in work")
    `SRWC_ASSERT_IMP(a_commit_slot_free, i_clk, i_rst_n, o_cmd.commit, !i_sts.out_busy, "result committed over an untaken result")
    `SRWC_ASSERT_IMP(a_walk_bounded, i_clk, i_rst_n, o_cmd.walk_step, !i_sts.walk_done, "bitmap fill ran past the skipped range")

endmodule

// File: design/seqno_replay_window_check_core.sv
`timescale 1ns / 1ps
// Anti-replay window check for received packet sequence numbers. Each input
// transaction carries one 32-bit sequence number and yields exactly one result
// transaction with a verdict (accepted, accepted after loss resync, dropped
// far future, dropped late or replayed), the lost count for far-future cases
// and a key-renewal flag. An item passes from the input transaction through
// the remainder steps and the classify step to the commit of its result; a
// packet that jumps ahead inside the window also goes through the bitmap fill,
// which marks its skipped sequence numbers (up to 126), and the commit waits
// while the output still holds an untaken result. The remainder unit finds
// the bitmap byte, 4 dividend bits a cycle; the bitmap fill marks one skipped
// number per cycle. One item is in work at a time; a finished result sits
// in the output register while the next input is taken. The bitmap lives in
// flip-flops cleared by reset, so no clearing pass follows reset.
// Configuration writes are expected only while no item is in work.

module seqno_replay_window_check_core import srwc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // configuration: index 0 window_bytes, index 1 seq_limit
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] seq_number

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // [1:0] verdict, [33:2] lost_count,
                                                 // [34] key_expired, [39:35] zero
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: accept, remainder steps, classify, fill, commit
    srwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // window state, bitmap, remainder unit, walker and output register
    srwc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_seq       (s_axis_tdata[SEQ_W-1:0]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// File: test/seqno_replay_window_check_core_checker.sv
`timescale 1ns / 1ps

// Watches the config port and both stream channels, keeps a shadow of the
// replay window and compares every result transaction with its prediction.
module seqno_replay_window_check_core_checker
    import srwc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_DATA_W-1:0]   i_s_tdata,   // [31:0] seq_number

    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_DATA_W-1:0]  i_m_tdata,   // [1:0] verdict, [33:2] lost_count,
                                                // [34] key_expired

    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked,
    output logic [SEQ_W-1:0]       o_highest_seq,
    output logic [3:0][15:0]       o_verdict_hits
);

    typedef struct packed {
        t_verdict          verdict;
        logic [SEQ_W-1:0]  lost;
        logic              expired;
    } t_window_result;

    // shadow of the block's registers and window state
    logic [WB_W-1:0]   win_bytes;
    logic [SEQ_W-1:0]  seq_limit;
    logic [SEQ_W-1:0]  top_seq;
    logic [FC_W-1:0]   far_cnt;
    logic [BYTE_W-1:0] late_map [MAX_WINDOW_BYTES];

    t_window_result    verdict_q[$];
    int                errors;
    int                checked;
    logic [3:0][15:0]  hits;

    function automatic int byte_slot(input logic [SEQ_W-1:0] seq, input logic [WB_W-1:0] w);
        return int'((seq >> 3) % SEQ_W'(w));
    endfunction

    function automatic void mark_late(input logic [SEQ_W-1:0] seq, input logic [WB_W-1:0] w,
                                      input logic on);
        late_map[byte_slot(seq, w)][seq[BIT_W-1:0]] = on;
    endfunction

    // Window decision for one sequence number; updates the shadow state.
    function automatic t_window_result judge_seq(input logic [SEQ_W-1:0] seq);
        t_window_result   res;
        logic [WB_W-1:0]  w;
        logic [SEQ_W-1:0] span;
        logic [SEQ_W-1:0] i;
        logic [FC_W-1:0]  old_cnt;
        logic             dropped;
        logic             too_old;
        logic             missing;

        res.verdict = VERDICT_ACCEPT;
        res.lost    = '0;
        res.expired = 1'b0;
        dropped     = 1'b0;
        w    = (win_bytes > MAX_WINDOW_BYTES) ? WB_W'(MAX_WINDOW_BYTES) : win_bytes;
        span = SEQ_W'(w) << 3;

        if (w != '0) begin
            if (seq != top_seq + 32'd1) begin
                // window end wraps mod 2^32, so this compare is on the wrapped sum
                if (seq >= top_seq + span) begin
                    old_cnt = far_cnt;
                    res.lost = seq - top_seq - 32'd1;
                    if (far_cnt != FC_MAX)
                        far_cnt = far_cnt + 1'b1;
                    if (old_cnt < (w >> 2)) begin
                        res.verdict = VERDICT_DROP_FAR;
                        dropped     = 1'b1;
                    end else begin
                        res.verdict = VERDICT_RESYNC;
                        for (int b = 0; b < MAX_WINDOW_BYTES; b++)
                            if (b < w) late_map[b] = '0;
                    end
                end else if (seq <= top_seq) begin
                    too_old = (top_seq >= span) && (seq <= top_seq - span);
                    missing = !late_map[byte_slot(seq, w)][seq[BIT_W-1:0]];
                    if (too_old || missing) begin
                        res.verdict = VERDICT_DROP_LATE;
                        dropped     = 1'b1;
                    end
                end else begin
                    for (i = top_seq + 32'd1; i < seq; i++)
                        mark_late(i, w, 1'b1);
                end
            end
            if (!dropped) begin
                far_cnt = '0;
                mark_late(seq, w, 1'b0);
            end
        end

        if (!dropped) begin
            if (seq > top_seq)
                top_seq = seq;
            res.expired = (top_seq > seq_limit);
        end
        return res;
    endfunction

    task automatic report(input string what, input logic [SEQ_W-1:0] got_v,
                          input logic [SEQ_W-1:0] want_v);
        $display("[checker] %0t: %s: got 0x%0h, want 0x%0h (result %0d)",
                 $realtime, what, got_v, want_v, checked);
        errors++;
    endtask

    always @(posedge i_clk) begin : watch
        t_window_result got;
        t_window_result want;

        if (!i_rst_n) begin
            win_bytes = WB_RESET;
            seq_limit = LIMIT_RESET;
            top_seq   = '0;
            far_cnt   = '0;
            foreach (late_map[b]) late_map[b] = '0;
            verdict_q.delete();
        end else begin
            // result side first: a result never belongs to the item taken this edge
            if (i_m_tvalid && i_m_tready) begin
                got.verdict = t_verdict'(i_m_tdata[VERDICT_W-1:0]);
                got.lost    = i_m_tdata[VERDICT_W+SEQ_W-1:VERDICT_W];
                got.expired = i_m_tdata[VERDICT_W+SEQ_W];
                if (verdict_q.size() == 0) begin
                    report("result with no prediction pending", SEQ_W'(got.verdict), '0);
                end else begin
                    want = verdict_q.pop_front();
                    checked++;
                    hits[want.verdict] = hits[want.verdict] + 16'd1;
                    if (got.verdict != want.verdict)
                        report("verdict", SEQ_W'(got.verdict), SEQ_W'(want.verdict));
                    if (got.lost != want.lost)
                        report("lost_count", got.lost, want.lost);
                    if (got.expired != want.expired)
                        report("key_expired", SEQ_W'(got.expired), SEQ_W'(want.expired));
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WINDOW_BYTES: win_bytes = i_cfg_data[WB_W-1:0];
                    REG_SEQ_LIMIT:    seq_limit = i_cfg_data[SEQ_W-1:0];
                    default: ;
                endcase
            end

            if (i_s_tvalid && i_s_tready)
                verdict_q.push_back(judge_seq(i_s_tdata[SEQ_W-1:0]));
        end

        o_pending      <= verdict_q.size();
        o_highest_seq  <= top_seq;
        o_fail_count   <= errors;
        o_checked      <= checked;
        o_verdict_hits <= hits;
    end

    initial begin
        errors  = 0;
        checked = 0;
        hits    = '0;
    end

endmodule

// File: test/seqno_replay_window_check_core_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the replay window core. The checker beside the
// block does all prediction; this module only drives traffic and config.
module seqno_replay_window_check_core_test;
    import srwc_pkg::*;

    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 54;
    localparam int DRAIN_WAIT  = 200;   // > worst item time, which includes the widest bitmap fill

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [31:0] seq_number
    logic                  m_axis_tready = 1'b0;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [1:0] verdict, [33:2] lost_count,
                                                 // [34] key_expired

    int               fail_count;
    int               pending;
    int               checked;
    logic [SEQ_W-1:0] top_seq;        // checker's view of the highest accepted seq
    logic [3:0][15:0] verdict_hits;

    // idle odds in percent, per cycle
    int               tx_idle_pct = 36;
    int               rx_idle_pct = 85;
    logic [WB_W-1:0]  win_bytes   = WB_RESET;   // last window size written

    seqno_replay_window_check_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    seqno_replay_window_check_core_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_highest_seq  (top_seq),
        .o_verdict_hits (verdict_hits)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Result side back-pressure: a fresh coin every cycle.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // One input transaction. tvalid drops for one cycle after each handshake
    // so the checker's highest-seq view has settled before the next seq is
    // picked; the block is busy for many cycles after a take anyway.
    task automatic send_seq(input logic [SEQ_W-1:0] seq);
        while ($urandom_range(99) < tx_idle_pct)
            @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= seq;
        do @(posedge i_clk); while (!s_axis_tready);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Register write, only with nothing in flight (every item gives a result,
    // so an empty prediction queue means the core is idle).
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_WINDOW_BYTES)
            win_bytes = val[WB_W-1:0];
    endtask

    // Mostly well-formed traffic around the current highest seq: in-order,
    // jumps inside the window, late/replayed numbers, far-future bursts, some long
    // enough to resync, the window edge, plus some fully random noise.
    task automatic run_traffic(input int quota);
        int               n;
        int               w;
        int               span;
        int               pick;
        int               reps;
        logic [SEQ_W-1:0] hs;
        logic [SEQ_W-1:0] seq;

        n = 0;
        while (n < quota) begin
            hs   = top_seq;
            w    = (win_bytes > MAX_WINDOW_BYTES) ? MAX_WINDOW_BYTES : int'(win_bytes);
            span = w * BYTE_W;
            reps = 1;
            pick = $urandom_range(99);
            if (w == 0)
                seq = (pick < 50) ? hs + $urandom_range(0, 3) : $urandom;
            else if (pick < 35)
                seq = hs + 32'd1;
            else if (pick < 55)
                seq = hs + $urandom_range(2, span - 1);
            else if (pick < 75)
                seq = hs - $urandom_range(0, span + 8);
            else if (pick < 85) begin
                // far future: repeat until the counter lets it resync, or stop short
                seq  = hs + span + ($urandom_range(1) ? $urandom_range(0, 300) : $urandom);
                reps = $urandom_range(1) ? (w >> 2) + 1 : $urandom_range(1, (w >> 2) + 1);
            end else if (pick < 92)
                seq = hs + span - $urandom_range(0, 1);
            else
                seq = $urandom;
            repeat (reps) send_seq(seq);
            n += reps;
        end
    endtask

    initial begin : stimulus
        logic [WB_W-1:0]       wb;
        logic [CFG_DATA_W-1:0] limit;
        logic [WB_W-1:0]       phase_wb [PHASES];

        phase_wb = '{5'd31, 5'd16, 5'd1, 5'd8, 5'd0, 5'd17, 5'd4, 5'd2,
                     5'd16, 5'd5, 5'd12, 5'd16};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset config (16-byte window, limit 0x4000_0000):
        // in order, late never-seen, replay, jump, late fill, replay again.
        send_seq(32'd1);
        send_seq(32'd0);
        send_seq(32'd1);
        send_seq(32'd6);
        send_seq(32'd3);
        send_seq(32'd3);
        send_seq(32'd5);
        // exactly at the window end: four far drops, then the resync
        repeat (5) send_seq(32'd134);
        send_seq(32'd135);
        send_seq(32'd262);   // widest jump: 126 numbers marked
        send_seq(32'd134);   // just beyond the back edge
        send_seq(32'd136);   // marked number arriving late

        // Tiny window resyncs at once; walk across the 2^32 wrap.
        write_reg(REG_WINDOW_BYTES, CFG_DATA_W'(3));
        write_reg(REG_SEQ_LIMIT, 32'hFFFF_FFFE);
        send_seq(32'hFFFF_FFF8);
        send_seq(32'hFFFF_FFFF);
        send_seq(32'h0000_0000);   // next after wrap, highest stays put
        send_seq(32'h0000_0005);
        send_seq(32'h0000_0100);   // ahead by wrapped compare only
        send_seq(32'hFFFF_FFFA);

        // Window off: everything accepted.
        write_reg(REG_WINDOW_BYTES, CFG_DATA_W'(0));
        write_reg(REG_SEQ_LIMIT, 32'h0000_0000);
        send_seq(32'h8000_0000);
        send_seq(32'h0000_0000);

        for (int p = 0; p < PHASES; p++) begin
            if (p == 4) begin
                tx_idle_pct = 85;
                rx_idle_pct = 36;
            end else if (p == 8) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            wb = phase_wb[p];
            if (p == 0 || p == 5)
                limit = '1;
            else if (p == 2 || p == 7)
                limit = '0;
            else if (p == 1)
                limit = CFG_DATA_W'(LIMIT_RESET);
            else
                limit = $urandom;
            // junk above the 5-bit field must be ignored
            write_reg(REG_WINDOW_BYTES, ($urandom & ~32'h1F) | CFG_DATA_W'(wb));
            write_reg(REG_SEQ_LIMIT, limit);
            run_traffic(PHASE_ITEMS);
        end

        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Checked %0d results over %0d window/limit settings (window 0 to 31, limit 0 to max).",
                 checked, PHASES + 3);
        $display("Verdicts seen: accept %0d, resync %0d, far-future drop %0d, late/replay drop %0d",
                 verdict_hits[VERDICT_ACCEPT], verdict_hits[VERDICT_RESYNC],
                 verdict_hits[VERDICT_DROP_FAR], verdict_hits[VERDICT_DROP_LATE]);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
